// ===== rtl/core/rsms_pkg.sv =====
// ----------------------------------------------------------------------------
// rsms_pkg : shared types and tables for the rotary switch matrix scanner
// Row/column translation ROMs, default geometry and the stage structs.
// ----------------------------------------------------------------------------
package rsms_pkg;

	localparam int ROWS_DEF     = 16;
	localparam int LOG_COLS_DEF = 14;
	localparam int PHY_COLS_DEF = 16;

	// Fixed physical sizes of the matrix ports
	localparam int MAX_ROWS = 16;
	localparam int MAX_COLS = 16;

	localparam logic [7:0] MAP_BAD = 8'hFF;
	localparam logic [3:0] NO_POS  = 4'd15;

	typedef enum logic {
		REQ_SAMPLE = 1'b0,
		REQ_READ   = 1'b1
	} req_type_t;

	// physical row -> logical switch position
	localparam logic [7:0] ROW_MAP [MAX_ROWS] = '{
		8'hFF, 8'hFF, 8'd11, 8'd9,  8'd7,  8'd5, 8'd3, 8'd1,
		8'hFF, 8'd12, 8'd10, 8'd8,  8'd6,  8'd4, 8'd2, 8'd0
	};

	// physical column -> logical column
	localparam logic [7:0] COL_MAP [MAX_COLS] = '{
		8'd1,  8'd3,  8'd5,  8'd7,  8'd9,  8'd11, 8'd13, 8'hFF,
		8'hFF, 8'd12, 8'd10, 8'd8,  8'd6,  8'd4,  8'd2,  8'd0
	};

	// decoded sample, decode -> state update
	typedef struct packed {
		logic                sample;     // row sample (else read)
		logic                clr_hit;    // row 0: drop hit marks first
		logic                sweep_end;  // last row of the sweep
		logic [3:0]          pos;        // translated switch position
		logic [MAX_COLS-1:0] rec_mask;   // logical columns closed on this row
	} rsms_scan_t;

	typedef struct packed {
		logic       changed;
		logic       sweep_end;
		logic       pos_valid;
		logic [3:0] position;
	} rsms_result_t;

endpackage

// ===== rtl/core/rsms_decode.sv =====
// ----------------------------------------------------------------------------
// rsms_decode : row/column translation of one transaction
// Maps the driven row and the closed columns onto logical columns.
// ----------------------------------------------------------------------------
module rsms_decode #(
	parameter int ROWS             = rsms_pkg::ROWS_DEF,
	parameter int LOGICAL_COLUMNS  = rsms_pkg::LOG_COLS_DEF,
	parameter int PHYSICAL_COLUMNS = rsms_pkg::PHY_COLS_DEF
) (
	input  logic                  req_type,
	input  logic [3:0]            row_index,
	input  logic [15:0]           col_sample,
	output rsms_pkg::rsms_scan_t  scan
);
	import rsms_pkg::*;

	logic       sample;
	logic       row_ok;
	logic       pos_ok;
	logic [7:0] rpos;

	assign sample = (req_type == REQ_SAMPLE);
	assign row_ok = ({1'b0, row_index} < 5'(ROWS));
	assign rpos   = ROW_MAP[row_index];
	assign pos_ok = (rpos != MAP_BAD);

	always_comb begin
		scan           = '0;
		scan.sample    = sample;
		scan.clr_hit   = sample && (row_index == 4'd0);
		scan.sweep_end = sample && (row_index == 4'(ROWS - 1));
		scan.pos       = rpos[3:0];
		for (int i = 0; i < MAX_COLS; i++) begin
			for (int k = 0; k < MAX_COLS; k++) begin
				if (k < PHYSICAL_COLUMNS && i < LOGICAL_COLUMNS && COL_MAP[k] == 8'(i)) begin
					if (sample && row_ok && pos_ok && !col_sample[k])
						scan.rec_mask[i] = 1'b1;
				end
			end
		end
	end

endmodule

// ===== rtl/core/rsms_state.sv =====
// ----------------------------------------------------------------------------
// rsms_state : knob position / hit mark registers and their update
// Applies one decoded transaction and forms its result.
// ----------------------------------------------------------------------------
module rsms_state #(
	parameter int LOGICAL_COLUMNS = rsms_pkg::LOG_COLS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   upd_en,
	input  rsms_pkg::rsms_scan_t   scan,
	input  logic [3:0]             read_column,
	output rsms_pkg::rsms_result_t res
);
	import rsms_pkg::*;

	logic [LOGICAL_COLUMNS-1:0][3:0] knob_q, knob_d;
	logic [LOGICAL_COLUMNS-1:0]      hit_q, hit_d;
	logic [LOGICAL_COLUMNS-1:0]      stale_ok;
	logic                            chg;
	logic [3:0]                      rd;

	always_comb begin
		chg    = 1'b0;
		knob_d = knob_q;
		for (int i = 0; i < LOGICAL_COLUMNS; i++) begin
			hit_d[i] = (scan.clr_hit ? 1'b0 : hit_q[i]) | scan.rec_mask[i];
			if (scan.rec_mask[i]) begin
				knob_d[i] = scan.pos;
				if (knob_q[i] != scan.pos)
					chg = 1'b1;
			end else if (scan.sweep_end && !hit_d[i]) begin
				knob_d[i] = NO_POS;
				if (knob_q[i] != NO_POS)
					chg = 1'b1;
			end
		end
	end

	// read port
	always_comb begin
		rd = NO_POS;
		for (int i = 0; i < LOGICAL_COLUMNS; i++) begin
			if (read_column == 4'(i))
				rd = knob_q[i];
		end
	end

	always_comb begin
		res.changed   = chg;
		res.sweep_end = scan.sweep_end;
		res.pos_valid = !scan.sample && (rd != NO_POS);
		res.position  = res.pos_valid ? rd : 4'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LOGICAL_COLUMNS; i++)
				knob_q[i] <= NO_POS;
			hit_q <= '0;
		end else if (upd_en) begin
			knob_q <= knob_d;
			hit_q  <= hit_d;
		end
	end

	always_comb begin
		for (int i = 0; i < LOGICAL_COLUMNS; i++)
			stale_ok[i] = hit_q[i] || (knob_q[i] == NO_POS);
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!upd_en |=> $stable(knob_q) && $stable(hit_q))
		else $error("state moved without a transaction");

	a_row0: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en && scan.clr_hit && !scan.sweep_end
		|=> hit_q == $past(scan.rec_mask[LOGICAL_COLUMNS-1:0]))
		else $error("row 0 did not restart the hit marks");

	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		upd_en && scan.sweep_end |=> &stale_ok)
		else $error("column not hit in sweep still holds a position");

	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		!scan.sample |-> !res.changed && !res.sweep_end)
		else $error("read reported a change");

endmodule

// ===== rtl/core/rotary_switch_matrix_scanner_top.sv =====
// ----------------------------------------------------------------------------
// rotary_switch_matrix_scanner_top : rotary switch matrix scanner
// Tracks rotary switch positions from row samples of a 16x16 switch matrix
// and answers position reads, one result transaction per input transaction.
// ----------------------------------------------------------------------------
//
//  channel  handshake             payload
//  -------  --------------------  ------------------------------------------
//  input    in_valid / in_ready   req_type, row_index, col_sample, read_column
//  output   out_valid / out_ready changed, sweep_end, pos_valid, position
//
//  Two register stages: an input stage (_s1) and a result stage (_s2).
//  A result reaches the result stage when its transaction leaves the input
//  stage; one transaction per cycle is sustained while out_ready is high.
//  Decode, state update and read all happen in the same cycle, so state
//  written by one transaction is seen by the next one.
//  Reset (arst_n low) empties both stages, sets every knob to no position
//  and clears the hit marks.
//  A stalled output holds its result; the input stage keeps one more
//  transaction and in_ready drops only when both stages are full and
//  out_ready is low.
//
module rotary_switch_matrix_scanner_top #(
	parameter int ROWS             = rsms_pkg::ROWS_DEF,
	parameter int LOGICAL_COLUMNS  = rsms_pkg::LOG_COLS_DEF,
	parameter int PHYSICAL_COLUMNS = rsms_pkg::PHY_COLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        req_type,
	input  logic [3:0]  row_index,
	input  logic [15:0] col_sample,
	input  logic [3:0]  read_column,
	// output channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic        changed,
	output logic        sweep_end,
	output logic        pos_valid,
	output logic [3:0]  position
);
	import rsms_pkg::*;

	// input stage
	logic        vld_s1;
	logic        req_s1;
	logic [3:0]  row_s1;
	logic [15:0] col_s1;
	logic [3:0]  rdcol_s1;

	// result stage
	logic         vld_s2;
	rsms_result_t res_s2;

	rsms_scan_t   scan;
	rsms_result_t res;
	logic         in_acc;
	logic         adv_s1;

	// s1 moves on whenever the result stage is empty or being drained
	assign adv_s1   = vld_s1 && (!vld_s2 || out_ready);
	assign in_ready = !vld_s1 || adv_s1;
	assign in_acc   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			req_s1   <= req_type;
			row_s1   <= row_index;
			col_s1   <= col_sample;
			rdcol_s1 <= read_column;
		end
	end

	rsms_decode #(
		.ROWS             (ROWS),
		.LOGICAL_COLUMNS  (LOGICAL_COLUMNS),
		.PHYSICAL_COLUMNS (PHYSICAL_COLUMNS)
	) u_decode (
		.req_type   (req_s1),
		.row_index  (row_s1),
		.col_sample (col_s1),
		.scan       (scan)
	);

	// state commits exactly when the transaction moves into the result stage
	rsms_state #(
		.LOGICAL_COLUMNS (LOGICAL_COLUMNS)
	) u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.upd_en      (adv_s1),
		.scan        (scan),
		.read_column (rdcol_s1),
		.res         (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (out_ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_s2 <= res;
	end

	assign out_valid = vld_s2;
	assign changed   = res_s2.changed;
	assign sweep_end = res_s2.sweep_end;
	assign pos_valid = res_s2.pos_valid;
	assign position  = res_s2.position;

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s1 |-> in_ready)
		else $error("input stage empty but not ready");

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && vld_s2 && !out_ready |=> vld_s1 && vld_s2)
		else $error("transaction lost under output stall");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> out_valid)
		else $error("advanced transaction did not reach the result stage");

endmodule
